[hw/rtl/tkl_pkg.sv]
// Shared types and constants for the top-K leaderboard upsert block.
`timescale 1ns / 1ps

package tkl_pkg;

    localparam int IN_KEY_W   = 32;
    localparam int SCORE_W    = 64;
    localparam int RANK_OUT_W = 7;
    localparam int WIDE_W     = 64;

    typedef logic signed [SCORE_W-1:0] score_t;

    // Per-slot status handed between neighboring cells
    typedef struct packed {
        logic used;
        logic ge;
    } tkl_flag_t;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } tkl_state_t;

endpackage

[hw/rtl/tkl_in_if.sv]
// Request channel interface: key and score of one upsert.
`timescale 1ns / 1ps

interface tkl_in_if;
    import tkl_pkg::*;

    logic                valid;
    logic                ready;
    logic [IN_KEY_W-1:0] entry_key;
    score_t              entry_score;

    modport source (output valid, output entry_key, output entry_score, input ready);
    modport sink   (input valid, input entry_key, input entry_score, output ready);
endinterface

[hw/rtl/tkl_out_if.sv]
// Response channel interface: new rank and the key that left the table.
`timescale 1ns / 1ps

interface tkl_out_if;
    import tkl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RANK_OUT_W-1:0] new_rank;
    logic                  dropped_valid;
    logic [IN_KEY_W-1:0]   dropped_key;

    modport source (output valid, output new_rank, output dropped_valid, output dropped_key,
                    input ready);
    modport sink   (input valid, input new_rank, input dropped_valid, input dropped_key,
                    output ready);
endinterface

[hw/rtl/tkl_cell.sv]
// One leaderboard slot: compares against the incoming entry and takes its new content.
`timescale 1ns / 1ps

module tkl_cell #(
    parameter int KEY_BITS = 32,
    parameter int RANK_W   = 7,
    parameter int INDEX    = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                apply,
    input  logic [KEY_BITS-1:0] cmp_key,
    input  tkl_pkg::score_t     cmp_score,
    input  logic [KEY_BITS-1:0] new_key,
    input  tkl_pkg::score_t     new_score,
    input  logic [KEY_BITS-1:0] prev_key,
    input  tkl_pkg::score_t     prev_score,
    input  tkl_pkg::tkl_flag_t  prev_flag,
    input  logic [KEY_BITS-1:0] next_key,
    input  tkl_pkg::score_t     next_score,
    input  tkl_pkg::tkl_flag_t  next_flag,
    input  logic                bef_in,
    output logic                bef_out,
    input  logic [RANK_W-1:0]   rank_in,
    output logic [RANK_W-1:0]   rank_out,
    output logic [KEY_BITS-1:0] key,
    output tkl_pkg::score_t     score,
    output tkl_pkg::tkl_flag_t  flag
);
    import tkl_pkg::*;

    localparam logic [RANK_W-1:0] MY_RANK = RANK_W'(INDEX + 1);

    logic [KEY_BITS-1:0] key_reg, key_next;
    score_t              score_reg, score_next;
    logic                used_reg, used_next;
    logic                match_reg, match_next;
    logic                ge_reg, ge_next;
    logic                at_or_bef;
    logic                cur_ge;
    logic                prv_ge;
    logic                ins;

    // Compare against the request as it is accepted
    always_comb
    begin
        match_next = match_reg;
        ge_next    = ge_reg;
        if (load)
        begin
            match_next = used_reg && (key_reg == cmp_key);
            ge_next    = used_reg && (key_reg != cmp_key) && (score_reg >= cmp_score);
        end
    end

    // Slot i of the table with the matching entry removed comes from i or i+1;
    // the new entry goes in front of the first such slot that scores below it.
    always_comb
    begin
        at_or_bef = bef_in | match_reg;
        cur_ge    = at_or_bef ? next_flag.ge : ge_reg;
        prv_ge    = bef_in ? ge_reg : prev_flag.ge;
        ins       = !cur_ge && prv_ge;

        key_next   = key_reg;
        score_next = score_reg;
        used_next  = used_reg;
        if (apply)
        begin
            if (cur_ge)
            begin
                key_next   = at_or_bef ? next_key : key_reg;
                score_next = at_or_bef ? next_score : score_reg;
                used_next  = at_or_bef ? next_flag.used : used_reg;
            end
            else if (prv_ge)
            begin
                key_next   = new_key;
                score_next = new_score;
                used_next  = 1'b1;
            end
            else
            begin
                key_next   = bef_in ? key_reg : prev_key;
                score_next = bef_in ? score_reg : prev_score;
                used_next  = bef_in ? used_reg : prev_flag.used;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            match_reg <= 1'b0;
            ge_reg    <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            match_reg <= match_next;
            ge_reg    <= ge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        score_reg <= score_next;
    end

    assign bef_out  = at_or_bef;
    assign rank_out = rank_in | (ins ? MY_RANK : '0);
    assign key      = key_reg;
    assign score    = score_reg;
    assign flag     = '{used: used_reg, ge: ge_reg};

endmodule

[hw/rtl/top_k_leaderboard_upsert_core.sv]
// Top level of the top-K leaderboard upsert block: cell chain, control and response register.
`timescale 1ns / 1ps

// Keeps up to TABLE_SIZE (key, score) entries sorted by score, highest first.
// req carries entry_key and entry_score; a transaction sets that key's score.
// A present key moves to its new place; a new key is inserted, pushing the
// lowest entry out of a full table. Ties go behind existing equal scores.
// rsp returns one transaction per request: new_rank (1 is highest, 0 if the
// entry is not kept), dropped_valid and dropped_key.
// Each slot is a cell; all cells compare with the request in the cycle it is
// accepted and shift in the S_APPLY state that follows, once the response
// register is free; rsp.valid rises out of that shift. A new request is not
// taken until the last one has shifted; the compare-then-shift sequence sets that.
// If rsp is stalled, the finished response holds in its register; the next
// request is still accepted and compared, and its shift waits until the held
// response is taken.
// Reset (rst_n low, asynchronous) empties the table at once.
module top_k_leaderboard_upsert_core #(
    parameter int TABLE_SIZE = 100,
    parameter int KEY_BITS   = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    tkl_in_if.sink    req,
    tkl_out_if.source rsp
);
    import tkl_pkg::*;

    localparam int RANK_W = $clog2(TABLE_SIZE + 1);

    tkl_state_t          state_reg, state_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    score_t              score_reg, score_next;
    logic                out_valid_reg, out_valid_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic                dv_reg, dv_next;
    logic [KEY_BITS-1:0] dk_reg, dk_next;

    logic                load;
    logic                apply;
    logic [WIDE_W-1:0]   in_key_wide;
    logic [KEY_BITS-1:0] in_key;
    logic [WIDE_W-1:0]   dk_wide;
    logic [15:0]         rank_wide;
    logic                drop_now;

    logic [KEY_BITS-1:0] cell_key   [TABLE_SIZE];
    score_t              cell_score [TABLE_SIZE];
    tkl_flag_t           cell_flag  [TABLE_SIZE];
    logic                bef_chain  [TABLE_SIZE+1];
    logic [RANK_W-1:0]   rank_chain [TABLE_SIZE+1];
    logic [TABLE_SIZE-1:0] used_vec;

    assign in_key_wide = WIDE_W'(req.entry_key);
    assign in_key      = in_key_wide[KEY_BITS-1:0];

    assign bef_chain[0]  = 1'b0;
    assign rank_chain[0] = '0;

    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] pk, nk;
        score_t              ps, ns;
        tkl_flag_t           pf, nf;

        if (i == 0)
        begin : g_first
            // Virtual slot above the top always outranks the new entry
            assign pk = '0;
            assign ps = '0;
            assign pf = '{used: 1'b1, ge: 1'b1};
        end
        else
        begin : g_mid_prev
            assign pk = cell_key[i-1];
            assign ps = cell_score[i-1];
            assign pf = cell_flag[i-1];
        end

        if (i == TABLE_SIZE - 1)
        begin : g_last
            assign nk = '0;
            assign ns = '0;
            assign nf = '{used: 1'b0, ge: 1'b0};
        end
        else
        begin : g_mid_next
            assign nk = cell_key[i+1];
            assign ns = cell_score[i+1];
            assign nf = cell_flag[i+1];
        end

        tkl_cell #(
            .KEY_BITS (KEY_BITS),
            .RANK_W   (RANK_W),
            .INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (load),
            .apply      (apply),
            .cmp_key    (in_key),
            .cmp_score  (req.entry_score),
            .new_key    (key_reg),
            .new_score  (score_reg),
            .prev_key   (pk),
            .prev_score (ps),
            .prev_flag  (pf),
            .next_key   (nk),
            .next_score (ns),
            .next_flag  (nf),
            .bef_in     (bef_chain[i]),
            .bef_out    (bef_chain[i+1]),
            .rank_in    (rank_chain[i]),
            .rank_out   (rank_chain[i+1]),
            .key        (cell_key[i]),
            .score      (cell_score[i]),
            .flag       (cell_flag[i])
        );

        assign used_vec[i] = cell_flag[i].used;
    end

    // Last slot leaves only for a new key that outranks it on a full table
    assign drop_now = cell_flag[TABLE_SIZE-1].used && !bef_chain[TABLE_SIZE]
                      && !cell_flag[TABLE_SIZE-1].ge;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        req.ready = 1'b0;
        apply     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_APPLY:
            begin
                apply = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign load = req.valid && req.ready;

    always_comb
    begin
        key_next       = load ? in_key : key_reg;
        score_next     = load ? req.entry_score : score_reg;
        out_valid_next = out_valid_reg;
        rank_next      = rank_reg;
        dv_next        = dv_reg;
        dk_next        = dk_reg;
        if (apply)
        begin
            out_valid_next = 1'b1;
            rank_next      = rank_chain[TABLE_SIZE];
            dv_next        = drop_now;
            dk_next        = drop_now ? cell_key[TABLE_SIZE-1] : '0;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        score_reg <= score_next;
        rank_reg  <= rank_next;
        dv_reg    <= dv_next;
        dk_reg    <= dk_next;
    end

    assign dk_wide   = WIDE_W'(dk_reg);
    assign rank_wide = 16'(rank_reg);

    assign rsp.valid         = out_valid_reg;
    assign rsp.new_rank      = rank_wide[RANK_OUT_W-1:0];
    assign rsp.dropped_valid = dv_reg;
    assign rsp.dropped_key   = dk_wide[IN_KEY_W-1:0];

    // Used slots always form a prefix of the row
    a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((used_vec >> 1) & ~used_vec) == '0)
        else $error("used slots are not a prefix");

    // A response appears only out of the shift cycle
    a_rsp_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_APPLY))
        else $error("response without a shift cycle");

    // An entry leaves only when the new one was placed
    a_drop_ranked: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.dropped_valid) |-> (rsp.new_rank != '0))
        else $error("drop reported for an entry that was not kept");

    // No request is taken while a shift is pending
    a_no_accept_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> !req.ready)
        else $error("request accepted during shift");

endmodule
